// ===== rtl/c2us_pkg.sv =====
// Shared types, constants and tables for the calendar to microsecond stamp converter.
package c2us_pkg;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [19:0] microsecond;
	} c2us_in_t;

	typedef struct packed {
		logic [51:0] stamp_us;
		logic        out_of_range;
	} c2us_out_t;

	localparam logic [11:0] BASE_YEAR  = 12'd2015;
	localparam logic [6:0]  BASE_C100  = 7'd15;
	localparam logic [8:0]  BASE_C400  = 9'd15;
	localparam logic [6:0]  C100_LAST  = 7'd99;
	localparam logic [8:0]  C400_LAST  = 9'd399;

	localparam logic [1:0]  STEP_HOUR   = 2'd0;
	localparam logic [1:0]  STEP_MINUTE = 2'd1;
	localparam logic [1:0]  STEP_SECOND = 2'd2;
	localparam logic [1:0]  STEP_USEC   = 2'd3;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     month_len = 5'd30;
			4'd2:                                        month_len = 5'd28;
			default:                                     month_len = 5'd0;
		endcase
	endfunction

	// Multiplier constant applied to the running total before each field is added.
	function automatic logic [19:0] step_k(input logic [1:0] s);
		case (s)
			STEP_HOUR:   step_k = 20'd24;
			STEP_MINUTE: step_k = 20'd60;
			STEP_SECOND: step_k = 20'd60;
			STEP_USEC:   step_k = 20'd1000000;
			default:     step_k = 20'd0;
		endcase
	endfunction

	// Index of the top set bit of the step constant.
	function automatic logic [4:0] step_top(input logic [1:0] s);
		case (s)
			STEP_HOUR:   step_top = 5'd4;
			STEP_MINUTE: step_top = 5'd5;
			STEP_SECOND: step_top = 5'd5;
			STEP_USEC:   step_top = 5'd19;
			default:     step_top = 5'd0;
		endcase
	endfunction

endpackage

// ===== rtl/calendar_to_microsecond_stamp.sv =====
// Top level of the calendar to microsecond stamp converter with its shared adder and sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | c2us_in_t  (date and time of day)
//   rsp     | out       | rsp_valid/rsp_ready  | c2us_out_t (stamp and range flag)
//
// A valid request is converted by the one 52-bit adder, which walks the years, walks the
// months and then forms the time of day by bit-serial shift-and-add; a flagged request
// goes straight to the result register.
// The block is ready again on the same clock edge that loads the result register.
// Reset is asynchronous and leaves the block idle with no result pending.
// A finished result waits in its register while the next request is accepted.
module calendar_to_microsecond_stamp #(
	parameter int YEAR_SPAN = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  c2us_pkg::c2us_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output c2us_pkg::c2us_out_t rsp
);
	import c2us_pkg::*;

	localparam logic [12:0] YEAR_LAST = 13'(2015 + YEAR_SPAN - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_YEARS  = 3'd1;
	localparam logic [2:0] ST_MONTHS = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_ADD    = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0]  state_q;
	c2us_in_t    f_q;
	logic        bad_q;
	logic [51:0] acc_q;
	logic [51:0] prod_q;
	logic [11:0] yr_q;
	logic [6:0]  c100_q;
	logic [8:0]  c400_q;
	logic [3:0]  mon_q;
	logic [1:0]  step_q;
	logic [4:0]  bit_q;
	c2us_out_t   rsp_q;
	logic        rsp_valid_q;

	logic        bad_in;
	logic        leap;
	logic [19:0] k_cur;
	logic [51:0] add_a;
	logic [51:0] add_b;
	logic [51:0] sum;
	logic        take;

	assign bad_in = ({1'b0, req.year} < {1'b0, BASE_YEAR}) || ({1'b0, req.year} > YEAR_LAST)
		|| (req.month < 4'd1) || (req.month > 4'd12)
		|| (req.day < 5'd1)
		|| (req.hour > 5'd23) || (req.minute > 6'd59) || (req.second > 6'd59)
		|| (req.microsecond > 20'd999999);

	assign leap  = ((yr_q[1:0] == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
	assign k_cur = step_k(step_q);

	always_comb begin
		add_a = acc_q;
		add_b = '0;
		case (state_q)
			ST_YEARS: begin
				add_b = leap ? 52'd366 : 52'd365;
			end
			ST_MONTHS: begin
				if (mon_q == f_q.month) begin
					add_b = 52'(f_q.day - 5'd1);
				end else begin
					add_b = 52'(month_len(mon_q))
						+ 52'((mon_q == 4'd2 && leap) ? 1'b1 : 1'b0);
				end
			end
			ST_MUL: begin
				add_a = {prod_q[50:0], 1'b0};
				add_b = k_cur[bit_q] ? acc_q : '0;
			end
			ST_ADD: begin
				add_a = prod_q;
				case (step_q)
					STEP_HOUR:   add_b = 52'(f_q.hour);
					STEP_MINUTE: add_b = 52'(f_q.minute);
					STEP_SECOND: add_b = 52'(f_q.second);
					default:     add_b = 52'(f_q.microsecond);
				endcase
			end
			default: begin
				add_b = '0;
			end
		endcase
	end

	assign sum  = add_a + add_b;
	assign take = rsp_valid_q && rsp_ready;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (take) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= bad_in ? ST_FIN : ST_YEARS;
					end
				end
				ST_YEARS: begin
					if (yr_q == f_q.year) begin
						state_q <= ST_MONTHS;
					end
				end
				ST_MONTHS: begin
					if (mon_q == f_q.month) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (bit_q == 5'd0) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= (step_q == STEP_USEC) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					f_q    <= req;
					bad_q  <= bad_in;
					acc_q  <= '0;
					yr_q   <= BASE_YEAR;
					c100_q <= BASE_C100;
					c400_q <= BASE_C400;
					mon_q  <= 4'd1;
				end
			end
			ST_YEARS: begin
				if (yr_q != f_q.year) begin
					acc_q  <= sum;
					yr_q   <= yr_q + 12'd1;
					c100_q <= (c100_q == C100_LAST) ? 7'd0 : c100_q + 7'd1;
					c400_q <= (c400_q == C400_LAST) ? 9'd0 : c400_q + 9'd1;
				end
			end
			ST_MONTHS: begin
				acc_q <= sum;
				mon_q <= mon_q + 4'd1;
				if (mon_q == f_q.month) begin
					step_q <= STEP_HOUR;
					bit_q  <= step_top(STEP_HOUR);
					prod_q <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= sum;
				if (bit_q != 5'd0) begin
					bit_q <= bit_q - 5'd1;
				end
			end
			ST_ADD: begin
				acc_q  <= sum;
				prod_q <= '0;
				if (step_q != STEP_USEC) begin
					step_q <= step_q + 2'd1;
					bit_q  <= step_top(step_q + 2'd1);
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.stamp_us     <= acc_q;
					rsp_q.out_of_range <= bad_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the calendar to microsecond stamp converter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import c2us_pkg::*;

	localparam int SPAN = 128;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_DATES = 1250;
	localparam longint unsigned US_PER_DAY = 64'd86400000000;
	localparam int MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam c2us_out_t EPOCH_STAMP = '{stamp_us: 52'd0, out_of_range: 1'b0};
	localparam c2us_out_t LAST_STAMP = '{stamp_us: 52'd4039286399999999, out_of_range: 1'b0};
	localparam c2us_out_t FLAGGED = '{stamp_us: 52'd0, out_of_range: 1'b1};

	typedef struct {
		c2us_in_t  date;
		bit        typed;
		c2us_out_t want;
	} directed_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	c2us_in_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	c2us_out_t rsp;

	c2us_out_t     pending_stamps [$];
	directed_row_t directed_rows [];
	bit            quiet = 1'b0;
	int            dates_sent = 0;
	int            stamps_checked = 0;
	int            flagged_seen = 0;
	int            mismatches = 0;
	int            stall_cycles = 0;

	calendar_to_microsecond_stamp #(.YEAR_SPAN(SPAN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic c2us_out_t stamp_of_date(input c2us_in_t d);
		c2us_out_t      r;
		longint unsigned days;
		longint unsigned tod;
		int unsigned    yr;
		int unsigned    mo;
		r = '0;
		yr = d.year;
		if (yr < BASE_YEAR || yr > BASE_YEAR + SPAN - 1 || d.month < 1 || d.month > 12
				|| d.day < 1 || d.hour > 23 || d.minute > 59 || d.second > 59
				|| d.microsecond > 999999) begin
			r.out_of_range = 1'b1;
			return r;
		end
		days = 0;
		for (int unsigned y = BASE_YEAR; y < yr; y++)
			days += leap_year(y) ? 366 : 365;
		for (mo = 1; mo < d.month; mo++) begin
			days += MONTH_DAYS[mo];
			if (mo == 2 && leap_year(yr))
				days += 1;
		end
		days += d.day - 1;
		tod = ((longint'(d.hour) * 3600 + longint'(d.minute) * 60 + d.second) * 1000000)
			+ d.microsecond;
		r.stamp_us = 52'(days * US_PER_DAY + tod);
		return r;
	endfunction

	function automatic c2us_in_t date_of(input int y, input int mo, input int d, input int h,
			input int mi, input int s, input int us);
		c2us_in_t r;
		r.year = 12'(y);
		r.month = 4'(mo);
		r.day = 5'(d);
		r.hour = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		r.microsecond = 20'(us);
		return r;
	endfunction

	// Mostly well-formed dates; the rest have one or all fields filled with raw bits.
	function automatic c2us_in_t random_date();
		c2us_in_t r;
		r = date_of($urandom_range(2142, 2015), $urandom_range(12, 1), $urandom_range(31, 1),
			$urandom_range(23, 0), $urandom_range(59, 0), $urandom_range(59, 0),
			$urandom_range(999999, 0));
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(7))
				0: r.year = 12'($urandom);
				1: r.month = 4'($urandom);
				2: r.day = 5'($urandom);
				3: r.hour = 5'($urandom);
				4: r.minute = 6'($urandom);
				5: r.second = 6'($urandom);
				6: r.microsecond = 20'($urandom);
				default: r = 58'({$urandom, $urandom});
			endcase
		end
		return r;
	endfunction

	task automatic offer_date(input c2us_in_t date, input c2us_out_t want);
		while (!quiet && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= date;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_stamps.push_back(want);
		dates_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_ready <= quiet || ($urandom_range(99) >= 13);

	always @(posedge clk) begin : check_results
		c2us_out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_stamps.size() == 0) begin
				$error("Unexpected transaction: stamp_us %0d out_of_range %0b",
					rsp.stamp_us, rsp.out_of_range);
				mismatches++;
			end else begin
				want = pending_stamps.pop_front();
				stamps_checked++;
				if (rsp.out_of_range)
					flagged_seen++;
				if (rsp.stamp_us !== want.stamp_us) begin
					$error("stamp_us: expected %0d, got %0d", want.stamp_us, rsp.stamp_us);
					mismatches++;
				end
				if (rsp.out_of_range !== want.out_of_range) begin
					$error("out_of_range: expected %0b, got %0b",
						want.out_of_range, rsp.out_of_range);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		c2us_out_t want;
		directed_rows = '{
			'{date_of(2015, 1, 1, 0, 0, 0, 0), 1'b1, EPOCH_STAMP},
			'{date_of(2142, 12, 31, 23, 59, 59, 999999), 1'b1, LAST_STAMP},
			'{date_of(2014, 12, 31, 23, 59, 59, 999999), 1'b1, FLAGGED},
			'{date_of(2143, 1, 1, 0, 0, 0, 0), 1'b1, FLAGGED},
			'{date_of(0, 6, 15, 12, 30, 30, 500000), 1'b1, FLAGGED},
			'{date_of(4095, 6, 15, 12, 30, 30, 500000), 1'b1, FLAGGED},
			'{date_of(2020, 0, 10, 1, 2, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 13, 10, 1, 2, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 15, 10, 1, 2, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 0, 1, 2, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 24, 2, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 31, 2, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 1, 60, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 1, 63, 3, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 1, 2, 60, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 1, 2, 63, 4), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 1, 2, 3, 1000000), 1'b1, FLAGGED},
			'{date_of(2020, 5, 10, 1, 2, 3, 20'hFFFFF), 1'b1, FLAGGED},
			'{date_of(4095, 15, 31, 31, 63, 63, 20'hFFFFF), 1'b1, FLAGGED},
			'{date_of(2016, 2, 29, 12, 34, 56, 789012), 1'b0, EPOCH_STAMP},
			'{date_of(2100, 2, 29, 6, 0, 0, 1), 1'b0, EPOCH_STAMP},
			'{date_of(2100, 3, 1, 6, 0, 0, 1), 1'b0, EPOCH_STAMP},
			'{date_of(2017, 2, 31, 0, 0, 0, 0), 1'b0, EPOCH_STAMP},
			'{date_of(2016, 12, 31, 23, 59, 59, 999999), 1'b0, EPOCH_STAMP},
			'{date_of(2141, 6, 15, 8, 45, 17, 123456), 1'b0, EPOCH_STAMP}
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			want = directed_rows[i].typed ? directed_rows[i].want
				: stamp_of_date(directed_rows[i].date);
			offer_date(directed_rows[i].date, want);
		end

		for (int n = 0; n < RANDOM_DATES; n++) begin
			c2us_in_t date;
			quiet = (n >= 500 && n < 750);
			date = random_date();
			offer_date(date, stamp_of_date(date));
		end
		quiet = 1'b0;
		req_valid <= 1'b0;

		while (pending_stamps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d dates, directed extremes and random, %0d stamps checked.",
			dates_sent, stamps_checked);
		$display("%0d results were flagged out of range, %0d mismatches.",
			flagged_seen, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
